[sv/lrc_pkg.sv]
// Shared types, widths and constants for the lidar ring classifier.
// Holds the tan^2 table of the ring boundaries in unsigned Q0.32.
// No dependencies.
package lrc_pkg;

   localparam int COORD_W   = 32;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int RING_W    = 4;
   localparam int TAN_W     = 29;
   localparam int NUM_BOUND = 9;
   localparam int HALF_BND  = 7;
   localparam int HALF_CNT_W = 3;
   localparam int PROD_W    = COORD_W + TAN_W;
   localparam int BND_W     = SQ_W + TAN_W;
   localparam int CMP_W     = SQ_W + COORD_W;
   localparam int NUM_STAGES = 7;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               last;
   } point_type;

   // round(tan^2(2k degrees) * 2^32) for k = 1..9.
   function automatic logic [TAN_W-1:0] tan2_q32(input logic [3:0] k);
      logic [TAN_W-1:0] t;
      begin
         case (k)
            4'd1:    t = 29'd5237541;
            4'd2:    t = 29'd21001355;
            4'd3:    t = 29'd47446076;
            4'd4:    t = 29'd84833018;
            4'd5:    t = 29'd133535705;
            4'd6:    t = 29'd194047876;
            4'd7:    t = 29'd266994293;
            4'd8:    t = 29'd353144737;
            4'd9:    t = 29'd453431762;
            default: t = '0;
         endcase
         tan2_q32 = t;
      end
   endfunction

endpackage

[sv/lidar_ring_classifier_core.sv]
// Top level of the lidar ring classifier: a seven-stage pipeline that sorts
// each point into one of sixteen elevation rings without forming the angle.
// Depends on lrc_pkg.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_stall   x, y, z coordinates, last point
//   rsp      out        rsp_valid / rsp_stall   x, y, z, ring, keep, upper half, last
//
// One request enters per cycle while req_stall is low; each response leaves from the final stage.
// The depth is set by the squaring, the 64 by 29 bit boundary products,
// which are split into two 32-bit halves and then summed, and the compare.
// Reset clears only the stage valid bits. A stall holds the output stage;
// empty stages upstream keep filling, so bubbles close up under a stall.
module lidar_ring_classifier_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lrc_pkg::COORD_W-1:0]   req_x_coord,
   input  logic [lrc_pkg::COORD_W-1:0]   req_y_coord,
   input  logic [lrc_pkg::COORD_W-1:0]   req_z_coord,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lrc_pkg::COORD_W-1:0]   rsp_x_out,
   output logic [lrc_pkg::COORD_W-1:0]   rsp_y_out,
   output logic [lrc_pkg::COORD_W-1:0]   rsp_z_out,
   output logic [lrc_pkg::RING_W-1:0]    rsp_ring,
   output logic                          rsp_keep,
   output logic                          rsp_upper_half,
   output logic                          rsp_last_out
);

   localparam int NS = lrc_pkg::NUM_STAGES;
   localparam int NB = lrc_pkg::NUM_BOUND;
   localparam int NH = lrc_pkg::HALF_BND;

   // Stage control.
   logic [NS:1] vld_ff;
   logic [NS:1] vld_in;
   logic [NS:1] adv;

   lrc_pkg::point_type pt_ff [1:NS];
   lrc_pkg::point_type pt_in;

   // Stage 1: magnitudes.
   logic [lrc_pkg::COORD_W-1:0] xm_ff, ym_ff, zm_ff;
   logic [lrc_pkg::COORD_W-1:0] xm_in, ym_in, zm_in;
   // Stage 2: squares.
   logic [lrc_pkg::SQ_W-1:0] xsq_ff, ysq_ff, zsq2_ff;
   logic [lrc_pkg::SQ_W-1:0] xsq_in, ysq_in, zsq2_in;
   // Stage 3: horizontal range squared.
   logic [lrc_pkg::SQ_W-1:0] r2_ff, z2s3_ff;
   logic [lrc_pkg::SQ_W-1:0] r2_in;
   // Stage 4: partial products of r2 * tan^2 for each boundary.
   logic [lrc_pkg::PROD_W-1:0] p0_ff [1:NB];
   logic [lrc_pkg::PROD_W-1:0] p1_ff [1:NB];
   logic [lrc_pkg::PROD_W-1:0] p0_in [1:NB];
   logic [lrc_pkg::PROD_W-1:0] p1_in [1:NB];
   logic [lrc_pkg::SQ_W-1:0]   z2s4_ff;
   // Stage 5: full products.
   logic [lrc_pkg::BND_W-1:0] bnd_ff [1:NB];
   logic [lrc_pkg::BND_W-1:0] bnd_in [1:NB];
   logic [lrc_pkg::SQ_W-1:0]  z2s5_ff;
   // Stage 6: compare of z^2 * 2^32 against each product.
   logic [NB:1] ge_ff, le_ff;
   logic [NB:1] ge_in, le_in;
   // Stage 7: result.
   logic [lrc_pkg::RING_W-1:0] ring_ff, ring_in;
   logic                       keep_ff, keep_in;
   logic                       upper_ff, upper_in;

   logic [lrc_pkg::CMP_W-1:0]      z2_scaled;
   logic                           z_neg, z_pos;
   logic [lrc_pkg::HALF_CNT_W-1:0] cnt_lo, cnt_hi;
   logic [lrc_pkg::RING_W-1:0]     ring_sum;

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      adv[NS] = !vld_ff[NS] || !rsp_stall;
      for (int s = NS - 1; s >= 1; s--) begin
         adv[s] = !vld_ff[s] || adv[s + 1];
      end
      vld_in[1] = req_valid;
      for (int s = 2; s <= NS; s++) begin
         vld_in[s] = vld_ff[s - 1];
      end
   end

   assign req_stall = !adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 1; s <= NS; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   // Point pass-through travels alongside the arithmetic.
   always_comb begin
      pt_in.x    = req_x_coord;
      pt_in.y    = req_y_coord;
      pt_in.z    = req_z_coord;
      pt_in.last = req_last_point;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pt_ff[1] <= pt_in;
      end
      for (int s = 2; s <= NS; s++) begin
         if (adv[s]) begin
            pt_ff[s] <= pt_ff[s - 1];
         end
      end
   end

   // Stage 1: magnitudes. The most negative value maps to 2^31, which fits.
   always_comb begin
      xm_in = req_x_coord[lrc_pkg::COORD_W-1] ? (~req_x_coord + 1'b1) : req_x_coord;
      ym_in = req_y_coord[lrc_pkg::COORD_W-1] ? (~req_y_coord + 1'b1) : req_y_coord;
      zm_in = req_z_coord[lrc_pkg::COORD_W-1] ? (~req_z_coord + 1'b1) : req_z_coord;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         xm_ff <= xm_in;
         ym_ff <= ym_in;
         zm_ff <= zm_in;
      end
   end

   // Stage 2: squares.
   always_comb begin
      xsq_in  = lrc_pkg::SQ_W'(xm_ff) * lrc_pkg::SQ_W'(xm_ff);
      ysq_in  = lrc_pkg::SQ_W'(ym_ff) * lrc_pkg::SQ_W'(ym_ff);
      zsq2_in = lrc_pkg::SQ_W'(zm_ff) * lrc_pkg::SQ_W'(zm_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         xsq_ff  <= xsq_in;
         ysq_ff  <= ysq_in;
         zsq2_ff <= zsq2_in;
      end
   end

   // Stage 3: both squares are at most 2^62, so the sum stays below 2^64.
   assign r2_in = xsq_ff + ysq_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         r2_ff   <= r2_in;
         z2s3_ff <= zsq2_ff;
      end
   end

   // Stage 4: each product is split into low and high 32-bit halves of r2.
   always_comb begin
      for (int k = 1; k <= NB; k++) begin
         p0_in[k] = lrc_pkg::PROD_W'(r2_ff[lrc_pkg::COORD_W-1:0])
                  * lrc_pkg::PROD_W'(lrc_pkg::tan2_q32(4'(k)));
         p1_in[k] = lrc_pkg::PROD_W'(r2_ff[lrc_pkg::SQ_W-1:lrc_pkg::COORD_W])
                  * lrc_pkg::PROD_W'(lrc_pkg::tan2_q32(4'(k)));
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int k = 1; k <= NB; k++) begin
            p0_ff[k] <= p0_in[k];
            p1_ff[k] <= p1_in[k];
         end
         z2s4_ff <= z2s3_ff;
      end
   end

   // Stage 5: recombine the halves.
   always_comb begin
      for (int k = 1; k <= NB; k++) begin
         bnd_in[k] = lrc_pkg::BND_W'(p0_ff[k])
                   + {p1_ff[k], {lrc_pkg::COORD_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int k = 1; k <= NB; k++) begin
            bnd_ff[k] <= bnd_in[k];
         end
         z2s5_ff <= z2s4_ff;
      end
   end

   // Stage 6: z^2 is scaled by 2^32 to line up with the Q0.32 products.
   assign z2_scaled = {z2s5_ff, {lrc_pkg::COORD_W{1'b0}}};

   always_comb begin
      for (int k = 1; k <= NB; k++) begin
         ge_in[k] = z2_scaled >= lrc_pkg::CMP_W'(bnd_ff[k]);
         le_in[k] = z2_scaled <= lrc_pkg::CMP_W'(bnd_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         ge_ff <= ge_in;
         le_ff <= le_in;
      end
   end

   // Stage 7: the ring is the number of boundaries from -14 to +14 degrees
   // that the angle reaches. At or above 16 degrees or at or below -18 degrees
   // the point is dropped. The origin falls out as ring 8 on its own.
   always_comb begin
      z_neg  = pt_ff[6].z[lrc_pkg::COORD_W-1];
      z_pos  = !z_neg && (pt_ff[6].z != '0);
      cnt_lo = '0;
      cnt_hi = '0;
      for (int k = 1; k <= NH; k++) begin
         cnt_lo = cnt_lo + lrc_pkg::HALF_CNT_W'(!z_neg || le_ff[k]);
         cnt_hi = cnt_hi + lrc_pkg::HALF_CNT_W'(z_pos && ge_ff[k]);
      end
      ring_sum = lrc_pkg::RING_W'(cnt_lo) + lrc_pkg::RING_W'(cnt_hi)
               + lrc_pkg::RING_W'(!z_neg);
      keep_in  = !(z_pos && ge_ff[NB - 1]) && !(z_neg && ge_ff[NB]);
      ring_in  = keep_in ? ring_sum : '0;
      upper_in = keep_in && ring_sum[lrc_pkg::RING_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         ring_ff  <= ring_in;
         keep_ff  <= keep_in;
         upper_ff <= upper_in;
      end
   end

   assign rsp_valid      = vld_ff[NS];
   assign rsp_x_out      = pt_ff[NS].x;
   assign rsp_y_out      = pt_ff[NS].y;
   assign rsp_z_out      = pt_ff[NS].z;
   assign rsp_last_out   = pt_ff[NS].last;
   assign rsp_ring       = ring_ff;
   assign rsp_keep       = keep_ff;
   assign rsp_upper_half = upper_ff;

endmodule
